// ----- design/pedal_command_slew_limiter_core_defines.svh -----
// Assertion macros shared by the slew limiter sources.
`ifndef PEDAL_COMMAND_SLEW_LIMITER_CORE_DEFINES_SVH
`define PEDAL_COMMAND_SLEW_LIMITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PCSL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define PCSL_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCSL_ASSERT(label, clk, rst, prop, msg)
`define PCSL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- design/pcsl_pkg.sv -----
package pcsl_pkg;

   localparam int PEDAL_W     = 16;
   localparam int SPEED_W     = 16;
   localparam int SPEED_INT_W = 8;
   localparam int STEP_W      = 13;
   localparam int CMD_OUT_W   = 13;
   localparam int FLOOR_OUT_W = 12;
   localparam int MIN_W       = 15;

   // Command and floor saturation point; the limiter's internal command width follows it.
   localparam int COMMAND_MAX = 4095;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE_STEP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_ENABLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_OFFSET   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIP_MARGIN    = 3'd5;

   typedef struct packed {
      logic [11:0] rate_step;
      logic        adapt_enable;
      logic [11:0] command_offset;
      logic [15:0] floor_gain;
      logic [11:0] floor_offset;
      logic [7:0]  slip_margin;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rate_step:      12'd50,
      adapt_enable:   1'b0,
      command_offset: 12'd300,
      floor_gain:     16'd13906,
      floor_offset:   12'd300,
      slip_margin:    8'd2
   };

   // Minimum trackers restart here at every window boundary.
   localparam logic [MIN_W-1:0] MIN_RESET = 15'd32000;

endpackage

// ----- design/pedal_command_slew_limiter_core.sv -----
// Pedal command slew limiter. Each accepted word (pedal value, frame flag, front and
// rear Q8.8 wheel speeds) yields one result word: the slew-limited command, the
// speed floor and the step sign. One word is taken per clock; the result is presented
// from a result register, fed by a single pass behind the input register that also
// updates the limit and window state.
// A stalled result lets the input register take one more word; the input then stalls
// until the result is taken.
// Configuration writes are taken every cycle and belong to idle periods only.
`include "pedal_command_slew_limiter_core_defines.svh"

module pedal_command_slew_limiter_core #(
   parameter int WINDOW_TICKS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [pcsl_pkg::PEDAL_W-1:0]           req_pedal_word,
   input  logic                                   req_frame_valid,
   input  logic [pcsl_pkg::SPEED_W-1:0]           req_front_speed,
   input  logic [pcsl_pkg::SPEED_W-1:0]           req_rear_speed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pcsl_pkg::CMD_OUT_W-1:0]  rsp_pedal_command,
   output logic [pcsl_pkg::FLOOR_OUT_W-1:0]       rsp_speed_floor,
   output logic                                   rsp_step_negative,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pcsl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pcsl_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import pcsl_pkg::*;

   cfg_type cfg;

   logic                 in_valid_ff, in_valid_in;
   logic [PEDAL_W-1:0]   in_pedal_ff, in_pedal_in;
   logic                 in_frame_ff, in_frame_in;
   logic [SPEED_W-1:0]   in_front_ff, in_front_in;
   logic [SPEED_W-1:0]   in_rear_ff, in_rear_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [CMD_OUT_W-1:0]   rsp_cmd_ff, rsp_cmd_in;
   logic [FLOOR_OUT_W-1:0]        rsp_floor_ff, rsp_floor_in;
   logic                          rsp_neg_ff, rsp_neg_in;

   logic                          advance;
   logic                          req_take;
   logic signed [STEP_W-1:0]      step;
   logic signed [CMD_OUT_W-1:0]   cmd_next;
   logic [FLOOR_OUT_W-1:0]        floor_next;

   // move the held word into the result register when that register frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   pcsl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcsl_step_ctrl #(
      .WINDOW_TICKS (WINDOW_TICKS)
   ) u_step_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .front_int (in_front_ff[SPEED_W-1:SPEED_W-SPEED_INT_W]),
      .rear_int  (in_rear_ff[SPEED_W-1:SPEED_W-SPEED_INT_W]),
      .step      (step)
   );

   pcsl_limit u_limit (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .advance       (advance),
      .pedal_word    (in_pedal_ff),
      .frame_valid   (in_frame_ff),
      .front_speed   (in_front_ff),
      .step          (step),
      .pedal_command (cmd_next),
      .speed_floor   (floor_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_pedal_in = in_pedal_ff;
      in_frame_in = in_frame_ff;
      in_front_in = in_front_ff;
      in_rear_in  = in_rear_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_pedal_in = req_pedal_word;
         in_frame_in = req_frame_valid;
         in_front_in = req_front_speed;
         in_rear_in  = req_rear_speed;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_floor_in = rsp_floor_ff;
      rsp_neg_in   = rsp_neg_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_cmd_in   = cmd_next;
         rsp_floor_in = floor_next;
         rsp_neg_in   = step[STEP_W-1];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_pedal_ff  <= in_pedal_in;
      in_frame_ff  <= in_frame_in;
      in_front_ff  <= in_front_in;
      in_rear_ff   <= in_rear_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_floor_ff <= rsp_floor_in;
      rsp_neg_ff   <= rsp_neg_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pedal_command = rsp_cmd_ff;
   assign rsp_speed_floor   = rsp_floor_ff;
   assign rsp_step_negative = rsp_neg_ff;

   `PCSL_ASSERT_NORST(a_reset_empty, clock, $past(reset) |-> !in_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")
   `PCSL_ASSERT(a_hold_input, clock, reset, in_valid_ff && rsp_valid_ff && rsp_stall |=> in_valid_ff && rsp_valid_ff, "word lost while result stalled")

endmodule

// ----- design/pcsl_csr.sv -----
module pcsl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pcsl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcsl_pkg::CSR_DATA_W-1:0] csr_wdata,
   output pcsl_pkg::cfg_type              cfg
);
   import pcsl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RATE_STEP:      cfg_in.rate_step      = csr_wdata[11:0];
            CSR_ADAPT_ENABLE:   cfg_in.adapt_enable   = csr_wdata[0];
            CSR_COMMAND_OFFSET: cfg_in.command_offset = csr_wdata[11:0];
            CSR_FLOOR_GAIN:     cfg_in.floor_gain     = csr_wdata[15:0];
            CSR_FLOOR_OFFSET:   cfg_in.floor_offset   = csr_wdata[11:0];
            CSR_SLIP_MARGIN:    cfg_in.slip_margin    = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;   // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/pcsl_step_ctrl.sv -----
`include "pedal_command_slew_limiter_core_defines.svh"

module pcsl_step_ctrl #(
   parameter int WINDOW_TICKS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pcsl_pkg::cfg_type                   cfg,
   input  logic                                advance,
   input  logic [pcsl_pkg::SPEED_INT_W-1:0]    front_int,
   input  logic [pcsl_pkg::SPEED_INT_W-1:0]    rear_int,
   output logic signed [pcsl_pkg::STEP_W-1:0]  step
);
   import pcsl_pkg::*;

   localparam int                CNT_W    = $clog2(WINDOW_TICKS);
   localparam logic [CNT_W-1:0]  WIN_LAST = CNT_W'(WINDOW_TICKS - 1);

   logic signed [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]         win_cnt_ff, win_cnt_in;
   logic [MIN_W-1:0]         min_front_ff, min_front_in;
   logic [MIN_W-1:0]         min_rear_ff, min_rear_in;

   logic [MIN_W-1:0]         front_low, rear_low;
   logic signed [MIN_W:0]    min_diff;
   logic                     slip;
   logic                     win_last;
   logic signed [STEP_W-1:0] step_pos;

   assign step_pos  = signed'({1'b0, cfg.rate_step});
   assign front_low = ({{(MIN_W-SPEED_INT_W){1'b0}}, front_int} < min_front_ff)
                      ? {{(MIN_W-SPEED_INT_W){1'b0}}, front_int} : min_front_ff;
   assign rear_low  = ({{(MIN_W-SPEED_INT_W){1'b0}}, rear_int} < min_rear_ff)
                      ? {{(MIN_W-SPEED_INT_W){1'b0}}, rear_int} : min_rear_ff;
   assign min_diff  = signed'({1'b0, rear_low}) - signed'({1'b0, front_low});
   assign slip      = min_diff > signed'((MIN_W+1)'(cfg.slip_margin));
   assign win_last  = win_cnt_ff >= WIN_LAST;

   always_comb begin
      step_in      = step_ff;
      win_cnt_in   = win_cnt_ff;
      min_front_in = min_front_ff;
      min_rear_in  = min_rear_ff;
      if (!cfg.adapt_enable) begin
         step_in = step_pos;
      end else if (win_last) begin
         // decide the step sign from the window just closed, then restart it
         step_in      = slip ? -step_pos : step_pos;
         win_cnt_in   = '0;
         min_front_in = MIN_RESET;
         min_rear_in  = MIN_RESET;
      end else begin
         win_cnt_in   = win_cnt_ff + CNT_W'(1);
         min_front_in = front_low;
         min_rear_in  = rear_low;
      end
   end

   assign step = step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= signed'({1'b0, CFG_RESET.rate_step});
         win_cnt_ff   <= '0;
         min_front_ff <= MIN_RESET;
         min_rear_ff  <= MIN_RESET;
      end else if (advance) begin
         step_ff      <= step_in;
         win_cnt_ff   <= win_cnt_in;
         min_front_ff <= min_front_in;
         min_rear_ff  <= min_rear_in;
      end
   end

   `PCSL_ASSERT(a_win_cnt_range, clock, reset, win_cnt_ff <= WIN_LAST, "window count past last tick")
   `PCSL_ASSERT(a_win_restart, clock, reset, advance && cfg.adapt_enable && win_last |=> win_cnt_ff == '0 && min_front_ff == MIN_RESET && min_rear_ff == MIN_RESET, "window did not restart")

endmodule

// ----- design/pcsl_limit.sv -----
`include "pedal_command_slew_limiter_core_defines.svh"

module pcsl_limit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcsl_pkg::cfg_type                      cfg,
   input  logic                                   advance,
   input  logic [pcsl_pkg::PEDAL_W-1:0]           pedal_word,
   input  logic                                   frame_valid,
   input  logic [pcsl_pkg::SPEED_W-1:0]           front_speed,
   input  logic signed [pcsl_pkg::STEP_W-1:0]     step,
   output logic signed [pcsl_pkg::CMD_OUT_W-1:0]  pedal_command,
   output logic [pcsl_pkg::FLOOR_OUT_W-1:0]       speed_floor
);
   import pcsl_pkg::*;

   localparam int CW    = $clog2(COMMAND_MAX + 1);
   localparam int SUM_W = PEDAL_W + 1;
   localparam int PRD_W = 2 * SPEED_W;
   localparam int LW    = ((CW > STEP_W - 1) ? CW : STEP_W - 1) + 2;

   localparam logic [SUM_W-1:0] CMD_MAX_S = SUM_W'(COMMAND_MAX);
   localparam logic [CW-1:0]    CMD_MAX_C = CW'(COMMAND_MAX);

   logic [CW-1:0]          prev_limit_ff, prev_limit_in;

   logic [PEDAL_W-1:0]     pedal_sel;
   logic [SUM_W-1:0]       cmd_sum;
   logic [CW-1:0]          cmd_sat;
   logic [PRD_W-1:0]       floor_prod;
   logic [SUM_W-1:0]       floor_sum;
   logic [CW-1:0]          floor_v;
   logic signed [LW-1:0]   limit;
   logic signed [LW-1:0]   cmd_ext, floor_ext, cmd_lim;

   assign pedal_sel  = frame_valid ? pedal_word : '0;
   assign cmd_sum    = {1'b0, pedal_sel} + SUM_W'(cfg.command_offset);
   assign cmd_sat    = (cmd_sum > CMD_MAX_S) ? CMD_MAX_C : cmd_sum[CW-1:0];

   // Q8.8 gain times Q8.8 speed, keep the integer part
   assign floor_prod = PRD_W'(cfg.floor_gain) * PRD_W'(front_speed);
   assign floor_sum  = {1'b0, floor_prod[PRD_W-1:SPEED_W]} + SUM_W'(cfg.floor_offset);
   assign floor_v    = (floor_sum > CMD_MAX_S) ? CMD_MAX_C : floor_sum[CW-1:0];

   assign limit      = signed'(LW'(prev_limit_ff)) + LW'(step);
   assign cmd_ext    = signed'(LW'(cmd_sat));
   assign floor_ext  = signed'(LW'(floor_v));
   assign cmd_lim    = (cmd_ext >= limit) ? limit : cmd_ext;

   assign prev_limit_in = (cmd_lim < floor_ext) ? floor_v : cmd_lim[CW-1:0];

   assign pedal_command = cmd_lim[CMD_OUT_W-1:0];
   assign speed_floor   = floor_ext[FLOOR_OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_limit_ff <= '0;
      end else if (advance) begin
         prev_limit_ff <= prev_limit_in;
      end
   end

   `PCSL_ASSERT(a_limit_above_floor, clock, reset, advance |=> prev_limit_ff >= $past(floor_v), "limit dropped below floor")
   `PCSL_ASSERT(a_limit_in_range, clock, reset, prev_limit_ff <= CMD_MAX_C, "limit above command maximum")

endmodule
